// File: src/dntt_pkg.sv
// shared types and status codes for the dns name to text converter
`timescale 1ns / 1ps

package dntt_pkg;

    // result status codes
    localparam logic [1:0] ST_CHAR       = 2'd0;
    localparam logic [1:0] ST_DONE       = 2'd1;
    localparam logic [1:0] ST_LONG_SMALL = 2'd2;
    localparam logic [1:0] ST_LONG_LARGE = 2'd3;

    typedef struct packed {
        logic [7:0] name_byte;
        logic       name_start;
    } dntt_in_t;

    typedef struct packed {
        logic [7:0]  out_char;
        logic [1:0]  status;
        logic [11:0] out_length;
        logic        last;
    } dntt_out_t;

    // up to four characters caused by one input beat
    typedef struct packed {
        logic [3:0][7:0] chars;
        logic [1:0]      last_idx;
        logic [1:0]      status;
        logic [11:0]     length;
    } dntt_grp_t;

endpackage

// File: src/dntt_parse.sv
// wire-format parser state and per-byte character group generation
`timescale 1ns / 1ps

module dntt_parse #(
    parameter int MAX_TEXT_LEN = 2048
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_wr_en,
    input  logic [11:0]       cfg_wr_data,
    input  logic              in_accept,
    input  dntt_pkg::dntt_in_t in_beat,
    output dntt_pkg::dntt_grp_t grp,
    output logic              grp_vld
);
    import dntt_pkg::*;

    localparam logic [12:0] MAX_CAP   = 13'(MAX_TEXT_LEN);
    localparam logic [11:0] CAP_RESET = 12'd1024;
    localparam logic [11:0] LARGE_BUF = 12'd1024;
    localparam logic [7:0]  CH_BSLASH = 8'h5c;
    localparam logic [7:0]  CH_DOT    = 8'h2e;
    localparam logic [7:0]  CH_ZERO   = 8'h30;

    logic [11:0] cap_reg;
    logic [11:0] wc_reg, wc_next;
    logic [7:0]  rem_reg, rem_next;
    logic        drop_reg, drop_next;

    logic [11:0] w;
    logic [7:0]  rem;
    logic        drop;
    logic [7:0]  b;
    logic [12:0] w13, cap13;
    logic        err;
    logic [1:0]  hund;
    logic [6:0]  r;
    logic [14:0] tprod;
    logic [3:0]  tens;
    logic [6:0]  ones;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_reg <= CAP_RESET;
        end else if (cfg_wr_en) begin
            cap_reg <= cfg_wr_data;
        end
    end

    // decimal digits of a byte
    always_comb begin
        b = in_beat.name_byte;
        if (b >= 8'd200) begin
            hund = 2'd2;
            r    = 7'(b - 8'd200);
        end else if (b >= 8'd100) begin
            hund = 2'd1;
            r    = 7'(b - 8'd100);
        end else begin
            hund = 2'd0;
            r    = b[6:0];
        end
        tprod = 15'(r) * 15'd205;
        tens  = tprod[14:11];
        ones  = r - 7'(tens) * 7'd10;
    end

    always_comb begin
        // name start clears the parser before the byte is handled
        w    = in_beat.name_start ? 12'd0 : wc_reg;
        rem  = in_beat.name_start ? 8'd0  : rem_reg;
        drop = in_beat.name_start ? 1'b0  : drop_reg;

        w13   = {1'b0, w};
        cap13 = ({1'b0, cap_reg} > MAX_CAP) ? MAX_CAP : {1'b0, cap_reg};

        wc_next   = w;
        rem_next  = rem;
        drop_next = drop;
        err       = 1'b0;
        grp_vld   = 1'b0;
        grp.chars    = '0;
        grp.last_idx = 2'd0;
        grp.status   = ST_CHAR;
        grp.length   = 12'd0;

        if (drop) begin
            grp_vld = 1'b0;
        end else if (rem == 8'd0) begin
            if (b == 8'd0) begin
                if (w13 >= cap13) begin
                    err = 1'b1;
                end else begin
                    grp_vld    = 1'b1;
                    grp.status = ST_DONE;
                    grp.length = 12'(w13 + 13'd1);
                    wc_next    = 12'(w13 + 13'd1);
                    drop_next  = 1'b1;
                end
            end else begin
                rem_next = b;
                if (w != 12'd0) begin
                    if (w13 >= cap13) begin
                        err = 1'b1;
                    end else begin
                        grp_vld      = 1'b1;
                        grp.chars[0] = CH_DOT;
                        wc_next      = 12'(w13 + 13'd1);
                    end
                end
            end
        end else begin
            rem_next = rem - 8'd1;
            case (b) inside
                8'h2e, 8'h5c, 8'h22, 8'h3b, 8'h40, 8'h24: begin
                    if ((w13 + 13'd2) > cap13) begin
                        err = 1'b1;
                    end else begin
                        grp_vld      = 1'b1;
                        grp.chars[0] = CH_BSLASH;
                        grp.chars[1] = b;
                        grp.last_idx = 2'd1;
                        wc_next      = 12'(w13 + 13'd2);
                    end
                end
                default: begin
                    if (b <= 8'h20 || b >= 8'h7f) begin
                        // strict margin on the decimal escape
                        if ((w13 + 13'd4) >= cap13) begin
                            err = 1'b1;
                        end else begin
                            grp_vld      = 1'b1;
                            grp.chars[0] = CH_BSLASH;
                            grp.chars[1] = CH_ZERO + 8'(hund);
                            grp.chars[2] = CH_ZERO + 8'(tens);
                            grp.chars[3] = CH_ZERO + 8'(ones);
                            grp.last_idx = 2'd3;
                            wc_next      = 12'(w13 + 13'd4);
                        end
                    end else if (w13 >= cap13) begin
                        err = 1'b1;
                    end else begin
                        grp_vld      = 1'b1;
                        grp.chars[0] = b;
                        wc_next      = 12'(w13 + 13'd1);
                    end
                end
            endcase
        end

        if (err) begin
            grp_vld      = 1'b1;
            grp.chars    = '0;
            grp.last_idx = 2'd0;
            grp.status   = (cap_reg >= LARGE_BUF) ? ST_LONG_LARGE : ST_LONG_SMALL;
            grp.length   = 12'd0;
            wc_next      = w;
            drop_next    = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wc_reg   <= 12'd0;
            rem_reg  <= 8'd0;
            drop_reg <= 1'b0;
        end else if (in_accept) begin
            wc_reg   <= wc_next;
            rem_reg  <= rem_next;
            drop_reg <= drop_next;
        end
    end

endmodule

// File: src/dntt_ser.sv
// result register that hands out a character group one beat at a time
`timescale 1ns / 1ps

module dntt_ser (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_accept,
    input  dntt_pkg::dntt_grp_t grp,
    input  logic                grp_vld,
    output logic                in_ready,
    output logic                m_valid,
    input  logic                m_ready,
    output dntt_pkg::dntt_out_t m_data
);
    import dntt_pkg::*;

    dntt_grp_t  grp_reg;
    logic       valid_reg;
    logic [1:0] idx_reg;
    logic       is_last;
    logic       drain;

    assign is_last  = (idx_reg == grp_reg.last_idx);
    assign drain    = valid_reg && m_ready && is_last;
    assign in_ready = !valid_reg || drain;

    assign m_valid           = valid_reg;
    assign m_data.out_char   = grp_reg.chars[idx_reg];
    assign m_data.status     = grp_reg.status;
    assign m_data.out_length = grp_reg.length;
    assign m_data.last       = is_last;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            idx_reg   <= 2'd0;
        end else if (in_accept && grp_vld) begin
            valid_reg <= 1'b1;
            idx_reg   <= 2'd0;
        end else if (drain) begin
            valid_reg <= 1'b0;
            idx_reg   <= 2'd0;
        end else if (valid_reg && m_ready) begin
            idx_reg <= idx_reg + 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_accept && grp_vld) begin
            grp_reg <= grp;
        end
    end

endmodule

// File: src/dns_name_to_text.sv
// top level: dns wire-format name bytes in, presentation text characters out
// output: an accepted byte's first character beat is presented in the cycle after the byte is taken
// throughput: the single result register drains one character per cycle while m_ready is high;
//   a byte yields 0 to 4 characters, and no new byte is taken until they are handed out
// a byte that yields no character leaves the result register free; the next byte is taken
//   in the same cycle as the last character of the previous one
// reset: synchronous active-low aresetn clears parser state and sets capacity to 1024
`timescale 1ns / 1ps

module dns_name_to_text #(
    parameter int MAX_TEXT_LEN = 2048
) (
    input  logic                aclk,
    input  logic                aresetn,
    // configuration: output buffer capacity
    input  logic                cfg_wr_en,
    input  logic [11:0]         cfg_wr_data,
    // wire-format byte beats
    input  logic                s_valid,
    output logic                s_ready,
    input  dntt_pkg::dntt_in_t  s_data,
    // text character beats
    output logic                m_valid,
    input  logic                m_ready,
    output dntt_pkg::dntt_out_t m_data
);
    import dntt_pkg::*;

    dntt_grp_t grp;
    logic      grp_vld;
    logic      in_accept;

    // a byte is taken whenever the result register is free or emptying now
    assign in_accept = s_valid && s_ready;

    // parser: label tracking, escaping and capacity checks in one pass
    dntt_parse #(
        .MAX_TEXT_LEN(MAX_TEXT_LEN)
    ) u_parse (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .in_accept  (in_accept),
        .in_beat    (s_data),
        .grp        (grp),
        .grp_vld    (grp_vld)
    );

    // result register: one character per beat, last flags the final one
    dntt_ser u_ser (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_accept(in_accept),
        .grp      (grp),
        .grp_vld  (grp_vld),
        .in_ready (s_ready),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data)
    );

endmodule

// File: sim/dntt_text_checker.sv
// result checker for the dns name to text converter: predicts text beats and compares them
`timescale 1ns / 1ps

module dntt_text_checker #(
    parameter int MAX_TEXT_LEN = 2048
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_wr_en,
    input  logic [11:0]         cfg_wr_data,
    input  logic                s_valid,
    input  logic                s_ready,
    input  dntt_pkg::dntt_in_t  s_data,
    input  logic                m_valid,
    input  logic                m_ready,
    input  dntt_pkg::dntt_out_t m_data,
    output int                  fail_count,
    output int                  pending_results,
    output int                  names_done,
    output int                  names_overflowed
);

    import dntt_pkg::*;

    localparam logic [7:0]  CH_NUL    = 8'h00;
    localparam logic [7:0]  CH_DOT    = 8'h2e;
    localparam logic [7:0]  CH_BSLASH = 8'h5c;
    localparam logic [7:0]  CH_QUOTE  = 8'h22;
    localparam logic [7:0]  CH_SEMI   = 8'h3b;
    localparam logic [7:0]  CH_AT     = 8'h40;
    localparam logic [7:0]  CH_DOLLAR = 8'h24;
    localparam logic [7:0]  CH_ZERO   = 8'h30;
    localparam logic [7:0]  CTRL_TOP  = 8'h20;
    localparam logic [7:0]  HIGH_BASE = 8'h7f;
    localparam logic [11:0] CAP_RESET = 12'd1024;
    localparam logic [11:0] CAP_LARGE = 12'd1024;

    dntt_out_t   expected_text[$];
    logic [11:0] cap_reg;
    int unsigned text_count;
    logic [7:0]  label_left;
    logic        skip_rest;
    int          beat_index;

    function automatic void queue_char(input logic [7:0] ch, input logic [1:0] st,
                                       input logic [11:0] len, input logic lst);
        dntt_out_t r;
        r.out_char   = ch;
        r.status     = st;
        r.out_length = len;
        r.last       = lst;
        expected_text.push_back(r);
    endfunction

    function automatic void queue_overflow();
        queue_char(CH_NUL, (cap_reg >= CAP_LARGE) ? ST_LONG_LARGE : ST_LONG_SMALL, 12'd0, 1'b1);
        skip_rest = 1'b1;
    endfunction

    // text beats that one wire byte yields, with the parser state advanced
    function automatic void predict_text(input dntt_in_t beat);
        int unsigned c;
        int unsigned w;
        int unsigned v;
        logic [7:0]  b;
        b = beat.name_byte;
        v = b;
        c = (cap_reg > MAX_TEXT_LEN) ? MAX_TEXT_LEN : cap_reg;
        if (beat.name_start) begin
            text_count = 0;
            label_left = 8'd0;
            skip_rest  = 1'b0;
        end
        if (skip_rest) return;
        w = text_count;
        if (label_left == 8'd0) begin
            if (b == 8'd0) begin
                if (w >= c) begin
                    queue_overflow();
                end else begin
                    text_count = w + 1;
                    queue_char(CH_NUL, ST_DONE, 12'(w + 1), 1'b1);
                    skip_rest = 1'b1;
                end
                return;
            end
            label_left = b;
            // no dot ahead of the first label
            if (w == 0) return;
            if (w >= c) begin
                queue_overflow();
                return;
            end
            queue_char(CH_DOT, ST_CHAR, 12'd0, 1'b1);
            text_count = w + 1;
        end else begin
            label_left = label_left - 8'd1;
            if (b == CH_DOT || b == CH_BSLASH || b == CH_QUOTE || b == CH_SEMI ||
                b == CH_AT || b == CH_DOLLAR) begin
                if (w + 2 > c) begin
                    queue_overflow();
                    return;
                end
                queue_char(CH_BSLASH, ST_CHAR, 12'd0, 1'b0);
                queue_char(b, ST_CHAR, 12'd0, 1'b1);
                text_count = w + 2;
            end else if (b <= CTRL_TOP || b >= HIGH_BASE) begin
                // strict margin on the numeric escape
                if (w + 4 >= c) begin
                    queue_overflow();
                    return;
                end
                queue_char(CH_BSLASH, ST_CHAR, 12'd0, 1'b0);
                queue_char(8'(CH_ZERO + v / 100), ST_CHAR, 12'd0, 1'b0);
                queue_char(8'(CH_ZERO + (v % 100) / 10), ST_CHAR, 12'd0, 1'b0);
                queue_char(8'(CH_ZERO + v % 10), ST_CHAR, 12'd0, 1'b1);
                text_count = w + 4;
            end else begin
                if (w >= c) begin
                    queue_overflow();
                    return;
                end
                queue_char(b, ST_CHAR, 12'd0, 1'b1);
                text_count = w + 1;
            end
        end
    endfunction

    function automatic void check_text(input dntt_out_t got);
        dntt_out_t want;
        if (expected_text.size() == 0) begin
            if (fail_count < 10)
                $display("beat %0d: unexpected text beat char %02h status %0d length %0d last %0b",
                         beat_index, got.out_char, got.status, got.out_length, got.last);
            fail_count++;
            beat_index++;
            return;
        end
        want = expected_text.pop_front();
        if (want.status == ST_DONE) names_done++;
        if (want.status == ST_LONG_SMALL || want.status == ST_LONG_LARGE) names_overflowed++;
        if (got.out_char !== want.out_char || got.status !== want.status ||
            got.out_length !== want.out_length || got.last !== want.last) begin
            if (fail_count < 10)
                $display("beat %0d: expected char %02h status %0d length %0d last %0b, %s",
                         beat_index, want.out_char, want.status, want.out_length, want.last,
                         $sformatf("got char %02h status %0d length %0d last %0b",
                                   got.out_char, got.status, got.out_length, got.last));
            fail_count++;
        end
        beat_index++;
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            cap_reg          = CAP_RESET;
            text_count       = 0;
            label_left       = 8'd0;
            skip_rest        = 1'b0;
            beat_index       = 0;
            fail_count       = 0;
            names_done       = 0;
            names_overflowed = 0;
            expected_text.delete();
        end else begin
            if (m_valid && m_ready) check_text(m_data);
            if (s_valid && s_ready) predict_text(s_data);
            if (cfg_wr_en) cap_reg = cfg_wr_data;
        end
        pending_results = expected_text.size();
    end

endmodule

// File: sim/dns_name_to_text_tb.sv
// testbench top for the dns name to text converter: stimulus, idling and verdict
`timescale 1ns / 1ps

module dns_name_to_text_tb;

    import dntt_pkg::*;

    localparam int MAX_TEXT_LEN = 2048;
    localparam int N_PHASES     = 8;
    localparam int PHASE_BYTES  = 10;
    localparam int HOLD_CYCLES  = 200;
    localparam int DRAIN_GAP    = 4;
    localparam int CYCLE_LIMIT  = 500000;

    logic       aclk        = 1'b0;
    logic       aresetn     = 1'b0;
    logic       cfg_wr_en   = 1'b0;
    logic [11:0] cfg_wr_data = 12'd0;
    logic       s_valid     = 1'b0;
    logic       s_ready;
    dntt_in_t   s_data      = '0;
    logic       m_valid;
    logic       m_ready     = 1'b0;
    dntt_out_t  m_data;

    int fail_count;
    int pending_results;
    int names_done;
    int names_overflowed;

    // shared between the sender and the receiver process
    logic idle_en  = 1'b1;
    logic hold_req = 1'b0;
    int   beats_pushed = 0;
    int   cap_writes = 0;
    int   cycle_count = 0;
    int   mark;
    int   phase;

    // one label that walks every escape class and both edges of the numeric escape
    logic [7:0] mixed_label[12] = '{8'h00, 8'h20, 8'h21, 8'h7e, 8'h7f, 8'hff,
                                    8'h2e, 8'h5c, 8'h22, 8'h3b, 8'h40, 8'h24};

    always #5 aclk = ~aclk;

    dns_name_to_text #(
        .MAX_TEXT_LEN(MAX_TEXT_LEN)
    ) dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data)
    );

    dntt_text_checker #(
        .MAX_TEXT_LEN(MAX_TEXT_LEN)
    ) text_check (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_data     (cfg_wr_data),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_data          (s_data),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_data          (m_data),
        .fail_count      (fail_count),
        .pending_results (pending_results),
        .names_done      (names_done),
        .names_overflowed(names_overflowed)
    );

    // watchdog on the whole run
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d beats still expected",
                     cycle_count, pending_results);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // receiver: random stall bursts, plus one long hold-off on request
    initial begin
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                // long hold so the result register fills and s_ready drops
                m_ready  <= 1'b0;
                hold_req = 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
            end else if (idle_en && $urandom_range(0, 5) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 16)) @(negedge aclk);
            end
            m_ready <= 1'b1;
        end
    end

    // offer one byte beat and hold it until taken; returns at a falling edge
    // with valid still high so back-to-back beats never toggle it
    task automatic push_beat(input logic [7:0] b, input logic st);
        dntt_in_t beat;
        beat.name_byte  = b;
        beat.name_start = st;
        if (idle_en && $urandom_range(0, 5) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(negedge aclk);
        end
        s_data  <= beat;
        s_valid <= 1'b1;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        beats_pushed++;
        @(negedge aclk);
    endtask

    // stop sending and wait for every predicted text beat, then a DRAIN_GAP idle tail
    // for bytes that yield nothing
    task automatic settle();
        s_valid <= 1'b0;
        while (pending_results != 0) @(negedge aclk);
        repeat (DRAIN_GAP) @(negedge aclk);
    endtask

    task automatic set_capacity(input logic [11:0] cap);
        settle();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= cap;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        cap_writes++;
    endtask

    // label content: mostly printable, a fair share of escaped punctuation,
    // the rest any byte at all
    function automatic logic [7:0] label_char();
        int r;
        r = $urandom_range(0, 9);
        if (r < 5) return 8'($urandom_range(8'h21, 8'h7e));
        if (r < 7) return mixed_label[$urandom_range(6, 11)];
        return 8'($urandom_range(0, 255));
    endfunction

    // one name: mostly well formed, some empty, some broken noise
    task automatic send_name();
        int kind;
        int n_labels;
        int len;
        int n;
        kind = $urandom_range(0, 9);
        if (kind == 0) begin
            push_beat(8'd0, 1'b1);
        end else if (kind <= 7) begin
            n_labels = $urandom_range(1, 4);
            for (int i = 0; i < n_labels; i++) begin
                len = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 6);
                push_beat(8'(len), i == 0);
                for (int j = 0; j < len; j++) push_beat(label_char(), 1'b0);
            end
            push_beat(8'd0, 1'b0);
            // junk after the terminator is dropped by the block
            if ($urandom_range(0, 3) == 0) push_beat(8'($urandom_range(0, 255)), 1'b0);
        end else begin
            // truncated or garbled, with stray name starts
            n = $urandom_range(1, 10);
            for (int i = 0; i < n; i++)
                push_beat(8'($urandom_range(0, 255)), i == 0 || $urandom_range(0, 5) == 0);
        end
    endtask

    // 255 numeric escapes fill a 1024 buffer to 1020, the dot takes 1021,
    // and the next escape trips the strict margin
    task automatic long_name();
        push_beat(8'hff, 1'b1);
        repeat (255)
            push_beat(($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 32))
                                                  : 8'($urandom_range(127, 255)), 1'b0);
        push_beat(8'd5, 1'b0);
        push_beat(8'($urandom_range(0, 32)), 1'b0);
        push_beat(8'h61, 1'b0);
        push_beat(8'd0, 1'b0);
    endtask

    function automatic logic [11:0] phase_capacity(input int p);
        case (p)
            0:       return 12'd2048;
            1:       return 12'd4095;
            2:       return 12'd1;
            3:       return 12'd1023;
            4:       return 12'd1024;
            default: return 12'($urandom_range(4, 48));
        endcase
    endfunction

    initial begin
        repeat (3) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed part at the reset capacity
        push_beat(8'd12, 1'b1);
        foreach (mixed_label[i]) push_beat(mixed_label[i], 1'b0);
        push_beat(8'd0, 1'b0);
        push_beat(8'h41, 1'b0);
        // pointer-looking length taken as a plain length, cut off by the next start
        push_beat(8'd1, 1'b1);
        push_beat(8'h61, 1'b0);
        push_beat(8'hc0, 1'b0);
        push_beat(8'h62, 1'b0);
        // empty name
        push_beat(8'd0, 1'b1);
        // one-character buffer: the terminator no longer fits
        set_capacity(12'd1);
        push_beat(8'd1, 1'b1);
        push_beat(8'h61, 1'b0);
        push_beat(8'd0, 1'b0);
        push_beat(8'h62, 1'b0);
        // zero capacity overflows even an empty name
        set_capacity(12'd0);
        push_beat(8'd0, 1'b1);

        // random part, one capacity per phase
        for (phase = 0; phase < N_PHASES; phase++) begin
            set_capacity(phase_capacity(phase));
            if (phase == 4) long_name();
            if (phase == 5) hold_req = 1'b1;
            // quiet tail: full rate on both sides
            if (phase >= N_PHASES - 2) idle_en = 1'b0;
            mark = beats_pushed;
            while (beats_pushed - mark < PHASE_BYTES) begin
                send_name();
                // one mid-phase pause until every text beat is back
                if (phase == 6 && beats_pushed - mark >= PHASE_BYTES / 2 && mark >= 0) begin
                    settle();
                    mark = -PHASE_BYTES;
                end
            end
        end

        settle();
        $display("sent %0d wire bytes over %0d buffer sizes; %0d names finished, %0d overflowed",
                 beats_pushed, cap_writes, names_done, names_overflowed);
        if (fail_count == 0 && pending_results == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

// File: dns_name_to_text.f
src/dntt_pkg.sv
src/dntt_parse.sv
src/dntt_ser.sv
src/dns_name_to_text.sv
sim/dntt_text_checker.sv
sim/dns_name_to_text_tb.sv
